FILE: design/dislocation_velocity_mobility_law_top_defines.svh
// Assertion macros for the glide-speed block checker.
// Used by dvml_checker.sv; expects clock and reset in scope.
`ifndef DISLOCATION_VELOCITY_MOBILITY_LAW_TOP_DEFINES_SVH
`define DISLOCATION_VELOCITY_MOBILITY_LAW_TOP_DEFINES_SVH

// check outside reset
`define DVML_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: check failed");

// check at every edge, reset included
`define DVML_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("%m: check failed");

`endif

FILE: design/dvml_pkg.sv
// Shared types, constants and sigmoid table entry function for the glide-speed block.
// No dependencies.
`timescale 1ns / 1ps
package dvml_pkg;

   typedef struct packed {
      logic advance;
      logic valid;
   } stage_ctl_type;

   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EDGE_DRAG_BASE = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EDGE_DRAG_SLOPE = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREW_DRAG_BASE = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREW_DRAG_SLOPE = 8'd3;
   localparam logic [CSR_DATA_BITS-1:0] DRAG_BASE_RESET = 32'd65536;
   localparam logic [CSR_DATA_BITS-1:0] DRAG_SLOPE_RESET = 32'd0;

   localparam int TEMP_BITS = 12;
   localparam int DRAG_PROD_BITS = 44;
   localparam int DRAG_BITS = 45;
   localparam int SPEED_CAP_BITS = 47;
   localparam logic [SPEED_CAP_BITS-1:0] SPEED_CAP = {SPEED_CAP_BITS{1'b1}};
   localparam int WEIGHT_BITS = 17;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 17'd65536;
   localparam int VELOCITY_BITS = 32;
   localparam int SQRT_PRESHIFT = 18;
   localparam int INDEX_PRESHIFT = 9;

   localparam longint unsigned SIG_SLOPE = 64'd40;
   localparam longint unsigned SIG_CENTRE_X_SLOPE = 64'd28;
   localparam longint unsigned ONE_Q31 = 64'd1 << 31;
   localparam longint unsigned ONE_Q16 = 64'd65536;

   // floor(n / d) by shift and subtract, d nonzero
   function automatic longint unsigned udiv_u64(longint unsigned n, longint unsigned d);
      logic [64:0] rem;
      longint unsigned q;
      rem = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= 65'(d)) begin
            rem = rem - 65'(d);
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-num/den) in Q31, series of exp(-a/32) squared five times
   function automatic longint unsigned exp_neg_q31(longint unsigned num,
                                                   longint unsigned den);
      longint unsigned t;
      longint unsigned sum;
      t = ONE_Q31;
      sum = ONE_Q31;
      for (int k = 1; k <= 24; k++) begin
         t = udiv_u64(t * num, den * 64'd32 * 64'(k));
         if ((k & 1) == 1) sum = sum - t;
         else sum = sum + t;
      end
      for (int j = 0; j < 5; j++) begin
         sum = (sum * sum + (ONE_Q31 >> 1)) >> 31;
      end
      return sum;
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] sig_entry(longint unsigned k,
                                                         longint unsigned m);
      longint unsigned p;
      longint unsigned q;
      longint unsigned z;
      longint unsigned d;
      p = SIG_CENTRE_X_SLOPE * m;
      q = SIG_SLOPE * k;
      if (p >= q) begin
         z = exp_neg_q31(p - q, m);
         d = ONE_Q31 + z;
         return WEIGHT_BITS'(udiv_u64(z * ONE_Q16 + (d >> 1), d));
      end
      z = exp_neg_q31(q - p, m);
      d = ONE_Q31 + z;
      return WEIGHT_BITS'(udiv_u64(ONE_Q31 * ONE_Q16 + (d >> 1), d));
   endfunction

endpackage

FILE: design/dvml_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on dvml_pkg (stage control).
`timescale 1ns / 1ps
module dvml_div #(
   parameter int NW = 8,
   parameter int DW = 8,
   parameter int QW = 8,
   parameter int SW = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dvml_pkg::stage_ctl_type ctl,
   input  logic [NW-1:0]           num,
   input  logic [DW-1:0]           den,
   input  logic [SW-1:0]           side_in,
   output logic                    out_valid,
   output logic [QW-1:0]           quot,
   output logic                    over,
   output logic [SW-1:0]           side_out
);
   import dvml_pkg::*;

   localparam int RW = (NW > DW + QW) ? NW : DW + QW;

   logic          valid_ff [QW+1];
   logic [RW-1:0] rem_ff [QW+1];
   logic [DW-1:0] den_ff [QW+1];
   logic [QW-1:0] quo_ff [QW+1];
   logic          over_ff [QW+1];
   logic [SW-1:0] side_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QW; s++) valid_ff[s] <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff[0] <= ctl.valid;
         for (int s = 1; s <= QW; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      logic [RW-1:0] trial;
      if (ctl.advance) begin
         rem_ff[0] <= RW'(num);
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         over_ff[0] <= (RW'(num) >> QW) >= RW'(den);
         side_ff[0] <= side_in;
         for (int s = 1; s <= QW; s++) begin
            trial = RW'(den_ff[s-1]) << (QW - s);
            if (rem_ff[s-1] >= trial) begin
               rem_ff[s] <= rem_ff[s-1] - trial;
               quo_ff[s] <= quo_ff[s-1] | (QW'(1) << (QW - s));
            end else begin
               rem_ff[s] <= rem_ff[s-1];
               quo_ff[s] <= quo_ff[s-1];
            end
            den_ff[s] <= den_ff[s-1];
            over_ff[s] <= over_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign quot = quo_ff[QW];
   assign over = over_ff[QW];
   assign side_out = side_ff[QW];
endmodule

FILE: design/dvml_sqrt.sv
// Pipelined integer square root, one root bit per stage (floor result).
// Depends on dvml_pkg (stage control).
`timescale 1ns / 1ps
module dvml_sqrt #(
   parameter int XW = 8,
   parameter int SW = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dvml_pkg::stage_ctl_type ctl,
   input  logic [XW-1:0]           radicand,
   input  logic [SW-1:0]           side_in,
   output logic                    out_valid,
   output logic [((XW+1)>>1)-1:0]  root,
   output logic [SW-1:0]           side_out
);
   import dvml_pkg::*;

   localparam int RW = (XW + 1) / 2;
   localparam int EW = XW + 1;

   logic          valid_ff [RW+1];
   logic [EW-1:0] rem_ff [RW+1];
   logic [RW-1:0] root_ff [RW+1];
   logic [SW-1:0] side_ff [RW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= RW; s++) valid_ff[s] <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff[0] <= ctl.valid;
         for (int s = 1; s <= RW; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      logic [EW-1:0] trial;
      if (ctl.advance) begin
         rem_ff[0] <= EW'(radicand);
         root_ff[0] <= '0;
         side_ff[0] <= side_in;
         for (int s = 1; s <= RW; s++) begin
            trial = (EW'(root_ff[s-1]) << (RW - s + 1)) + (EW'(1) << (2 * (RW - s)));
            if (rem_ff[s-1] >= trial) begin
               rem_ff[s] <= rem_ff[s-1] - trial;
               root_ff[s] <= root_ff[s-1] | (RW'(1) << (RW - s));
            end else begin
               rem_ff[s] <= rem_ff[s-1];
               root_ff[s] <= root_ff[s-1];
            end
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = valid_ff[RW];
   assign root = root_ff[RW];
   assign side_out = side_ff[RW];
endmodule

FILE: design/dvml_delay.sv
// Stall-aware delay line that aligns parallel pipeline branches.
// Depends on dvml_pkg (stage control).
`timescale 1ns / 1ps
module dvml_delay #(
   parameter int W = 1,
   parameter int DEPTH = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dvml_pkg::stage_ctl_type ctl,
   input  logic [W-1:0]            data_in,
   output logic                    out_valid,
   output logic [W-1:0]            data_out
);
   import dvml_pkg::*;

   if (DEPTH == 0) begin : g_pass
      assign out_valid = ctl.valid;
      assign data_out = data_in;
   end else begin : g_line
      logic         valid_ff [DEPTH];
      logic [W-1:0] data_ff [DEPTH];

      always_ff @(posedge clock) begin
         if (reset) begin
            for (int s = 0; s < DEPTH; s++) valid_ff[s] <= 1'b0;
         end else if (ctl.advance) begin
            valid_ff[0] <= ctl.valid;
            for (int s = 1; s < DEPTH; s++) valid_ff[s] <= valid_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            data_ff[0] <= data_in;
            for (int s = 1; s < DEPTH; s++) data_ff[s] <= data_ff[s-1];
         end
      end

      assign out_valid = valid_ff[DEPTH-1];
      assign data_out = data_ff[DEPTH-1];
   end
endmodule

FILE: design/dislocation_velocity_mobility_law_top.sv
// Glide-speed mobility law: resolved shear, drag division, sigmoid mixing.
// Depends on dvml_pkg, dvml_div, dvml_sqrt, dvml_delay.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  stress rows, b, tangent, normal, T
//   rsp      out        rsp_valid / rsp_ready  glide_velocity, zero_drag, saturated
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One beat per cycle while no rsp beat is held. Depth is set by the longer branch: the
// 47-bit speed dividers (one quotient bit a stage) or the sqrt and index-divider weight path.
// Reset clears valid bits and returns drag registers to base 65536, slope 0; the sigmoid table is a constant.
// A held rsp beat freezes every stage; nothing is dropped or repeated.
`timescale 1ns / 1ps
module dislocation_velocity_mobility_law_top #(
   parameter int COMPONENT_BITS = 20,
   parameter int FRACTION_BITS = 16,
   parameter int SIGMOID_TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [59:0]                         req_stress_row_x,
   input  logic [59:0]                         req_stress_row_y,
   input  logic [59:0]                         req_stress_row_z,
   input  logic [59:0]                         req_burgers_vector,
   input  logic [59:0]                         req_line_tangent,
   input  logic [59:0]                         req_plane_normal,
   input  logic [dvml_pkg::TEMP_BITS-1:0]      req_temperature,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dvml_pkg::VELOCITY_BITS-1:0]  rsp_glide_velocity,
   output logic                                rsp_zero_drag,
   output logic                                rsp_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dvml_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dvml_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import dvml_pkg::*;

   localparam int C = COMPONENT_BITS;
   localparam int F = FRACTION_BITS;
   localparam int MW = $clog2(SIGMOID_TABLE_DEPTH);
   localparam int M = SIGMOID_TABLE_DEPTH - 1;
   localparam int WW = 2 * C + 1;
   localparam int BBW = 2 * C;
   localparam int AXW = 2 * C;
   localparam int RSW = 2 * C + 2 - F;
   localparam int PW = C + RSW;
   localparam int TAUW = PW + 2;
   localparam int SH_L = (32 - 2 * F > 0) ? 32 - 2 * F : 0;
   localparam int SH_R = (2 * F > 32) ? 2 * F - 32 : 0;
   localparam int NUMW = TAUW + SH_L;
   localparam int XW = BBW + SQRT_PRESHIFT;
   localparam int NBW = (XW + 1) / 2;
   localparam int BXMW = AXW + MW;
   localparam int KNW = BXMW + INDEX_PRESHIFT + 1;
   localparam int LAT_A = (NBW + 1) + (MW + 1) + 1;
   localparam int LAT_B = SPEED_CAP_BITS + 1;
   localparam int LAT_MAX = (LAT_A > LAT_B) ? LAT_A : LAT_B;
   localparam int BW = 2 * SPEED_CAP_BITS + 4;

   typedef logic [WEIGHT_BITS-1:0] sig_rom_type [SIGMOID_TABLE_DEPTH];

   function automatic sig_rom_type build_sig_rom();
      sig_rom_type r;
      for (int k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin
         r[k] = sig_entry(64'(k), 64'(M));
      end
      return r;
   endfunction

   localparam sig_rom_type SIG_ROM = build_sig_rom();

   logic adv;
   logic rsp_valid_ff;
   logic [VELOCITY_BITS-1:0] rsp_vel_ff;
   logic rsp_zd_ff;
   logic rsp_sat_ff;

   assign adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   // drag registers
   logic [CSR_DATA_BITS-1:0] edge_base_ff, edge_slope_ff, screw_base_ff, screw_slope_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_base_ff <= DRAG_BASE_RESET;
         edge_slope_ff <= DRAG_SLOPE_RESET;
         screw_base_ff <= DRAG_BASE_RESET;
         screw_slope_ff <= DRAG_SLOPE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_EDGE_DRAG_BASE: edge_base_ff <= csr_data;
            REG_EDGE_DRAG_SLOPE: edge_slope_ff <= csr_data;
            REG_SCREW_DRAG_BASE: screw_base_ff <= csr_data;
            REG_SCREW_DRAG_SLOPE: screw_slope_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // unpack
   logic [63:0] row_ext [3];
   logic [63:0] b_ext, xi_ext, n_ext;
   logic signed [C-1:0] s_u [3][3];
   logic signed [C-1:0] b_u [3];
   logic signed [C-1:0] xi_u [3];
   logic signed [C-1:0] n_u [3];

   always_comb begin
      row_ext[0] = 64'(req_stress_row_x);
      row_ext[1] = 64'(req_stress_row_y);
      row_ext[2] = 64'(req_stress_row_z);
      b_ext = 64'(req_burgers_vector);
      xi_ext = 64'(req_line_tangent);
      n_ext = 64'(req_plane_normal);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) s_u[i][j] = $signed(row_ext[i][j*C +: C]);
         b_u[i] = $signed(b_ext[i*C +: C]);
         xi_u[i] = $signed(xi_ext[i*C +: C]);
         n_u[i] = $signed(n_ext[i*C +: C]);
      end
   end

   // stage A: products
   logic v_a_ff;
   logic signed [2*C-1:0] sn_a_ff [3][3];
   logic signed [2*C-1:0] bx_a_ff [3];
   logic signed [2*C-1:0] bsq_a_ff [3];
   logic signed [C-1:0] b_a_ff [3];
   logic [DRAG_PROD_BITS-1:0] ep_a_ff, sp_a_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               sn_a_ff[i][j] <= (2*C)'(s_u[i][j]) * (2*C)'(n_u[j]);
            end
            bx_a_ff[i] <= (2*C)'(b_u[i]) * (2*C)'(xi_u[i]);
            bsq_a_ff[i] <= (2*C)'(b_u[i]) * (2*C)'(b_u[i]);
            b_a_ff[i] <= b_u[i];
         end
         ep_a_ff <= DRAG_PROD_BITS'(edge_slope_ff) * DRAG_PROD_BITS'(req_temperature);
         sp_a_ff <= DRAG_PROD_BITS'(screw_slope_ff) * DRAG_PROD_BITS'(req_temperature);
      end
   end

   // stage B: sums
   logic v_b_ff;
   logic signed [WW-1:0] w_b_ff [3];
   logic signed [WW-1:0] bxi_b_ff;
   logic [BBW-1:0] bb_b_ff;
   logic [DRAG_BITS-1:0] de_b_ff, ds_b_ff;
   logic signed [C-1:0] b_b_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            w_b_ff[i] <= WW'(sn_a_ff[i][0]) + WW'(sn_a_ff[i][1]) + WW'(sn_a_ff[i][2]);
            b_b_ff[i] <= b_a_ff[i];
         end
         bxi_b_ff <= WW'(bx_a_ff[0]) + WW'(bx_a_ff[1]) + WW'(bx_a_ff[2]);
         bb_b_ff <= BBW'($unsigned(bsq_a_ff[0])) + BBW'($unsigned(bsq_a_ff[1]))
                  + BBW'($unsigned(bsq_a_ff[2]));
         de_b_ff <= DRAG_BITS'(edge_base_ff) + DRAG_BITS'(ep_a_ff);
         ds_b_ff <= DRAG_BITS'(screw_base_ff) + DRAG_BITS'(sp_a_ff);
      end
   end

   // stage C: round S.n, magnitudes, flags
   logic signed [RSW-1:0] rs_in [3];
   logic [AXW-1:0] abx_in;

   always_comb begin
      logic [WW-1:0] mag;
      logic [WW:0] rnd;
      logic [RSW-1:0] shv;
      for (int i = 0; i < 3; i++) begin
         mag = w_b_ff[i][WW-1] ? WW'(-w_b_ff[i]) : WW'(w_b_ff[i]);
         rnd = (WW+1)'(mag) + ((WW+1)'(1) << (F - 1));
         shv = RSW'(rnd >> F);
         rs_in[i] = w_b_ff[i][WW-1] ? -$signed(shv) : $signed(shv);
      end
      abx_in = bxi_b_ff[WW-1] ? AXW'(-bxi_b_ff) : AXW'(bxi_b_ff);
   end

   logic v_c_ff;
   logic signed [RSW-1:0] rs_c_ff [3];
   logic [AXW-1:0] abx_c_ff;
   logic [BBW-1:0] bb_c_ff;
   logic bbz_c_ff, zd_c_ff;
   logic [DRAG_BITS-1:0] de_c_ff, ds_c_ff;
   logic signed [C-1:0] b_c_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            rs_c_ff[i] <= rs_in[i];
            b_c_ff[i] <= b_b_ff[i];
         end
         abx_c_ff <= abx_in;
         bb_c_ff <= bb_b_ff;
         bbz_c_ff <= bb_b_ff == '0;
         zd_c_ff <= (de_b_ff == '0) || (ds_b_ff == '0);
         de_c_ff <= de_b_ff;
         ds_c_ff <= ds_b_ff;
      end
   end

   // stage D: b times rounded S.n, index numerator scale
   logic v_d_ff;
   logic signed [PW-1:0] bp_d_ff [3];
   logic [BXMW-1:0] bxm_d_ff;
   logic [BBW-1:0] bb_d_ff;
   logic bbz_d_ff, zd_d_ff;
   logic [DRAG_BITS-1:0] de_d_ff, ds_d_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            bp_d_ff[i] <= PW'(b_c_ff[i]) * PW'(rs_c_ff[i]);
         end
         bxm_d_ff <= BXMW'(abx_c_ff) * BXMW'(M);
         bb_d_ff <= bb_c_ff;
         bbz_d_ff <= bbz_c_ff;
         zd_d_ff <= zd_c_ff;
         de_d_ff <= de_c_ff;
         ds_d_ff <= ds_c_ff;
      end
   end

   // stage E: resolved shear magnitude, scaled numerator
   logic signed [TAUW-1:0] tau_in;
   logic [TAUW-1:0] tau_mag;

   always_comb begin
      tau_in = TAUW'(bp_d_ff[0]) + TAUW'(bp_d_ff[1]) + TAUW'(bp_d_ff[2]);
      tau_mag = tau_in[TAUW-1] ? TAUW'(-tau_in) : TAUW'(tau_in);
   end

   logic v_e_ff;
   logic [NUMW-1:0] num_e_ff;
   logic [XW-1:0] bbx_e_ff;
   logic [BXMW-1:0] bxm_e_ff;
   logic bbz_e_ff, zd_e_ff;
   logic [DRAG_BITS-1:0] de_e_ff, ds_e_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         num_e_ff <= (NUMW'(tau_mag) << SH_L) >> SH_R;
         bbx_e_ff <= XW'(bb_d_ff) << SQRT_PRESHIFT;
         bxm_e_ff <= bxm_d_ff;
         bbz_e_ff <= bbz_d_ff;
         zd_e_ff <= zd_d_ff;
         de_e_ff <= de_d_ff;
         ds_e_ff <= ds_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
         v_d_ff <= 1'b0;
         v_e_ff <= 1'b0;
      end else if (adv) begin
         v_a_ff <= req_valid;
         v_b_ff <= v_a_ff;
         v_c_ff <= v_b_ff;
         v_d_ff <= v_c_ff;
         v_e_ff <= v_d_ff;
      end
   end

   stage_ctl_type ctl_e;
   assign ctl_e = '{advance: adv, valid: v_e_ff};

   // speed branch
   logic ve_valid, vs_valid;
   logic [SPEED_CAP_BITS-1:0] qe, qs;
   logic ove, ovs, zd_se, zd_ss;

   dvml_div #(.NW(NUMW), .DW(DRAG_BITS), .QW(SPEED_CAP_BITS), .SW(1)) u_div_edge (
      .clock(clock), .reset(reset), .ctl(ctl_e), .num(num_e_ff), .den(de_e_ff),
      .side_in(zd_e_ff), .out_valid(ve_valid), .quot(qe), .over(ove), .side_out(zd_se)
   );

   dvml_div #(.NW(NUMW), .DW(DRAG_BITS), .QW(SPEED_CAP_BITS), .SW(1)) u_div_screw (
      .clock(clock), .reset(reset), .ctl(ctl_e), .num(num_e_ff), .den(ds_e_ff),
      .side_in(zd_e_ff), .out_valid(vs_valid), .quot(qs), .over(ovs), .side_out(zd_ss)
   );

   // weight branch
   logic sq_valid;
   logic [NBW-1:0] nb;
   logic [BXMW:0] sq_side;

   dvml_sqrt #(.XW(XW), .SW(BXMW + 1)) u_sqrt (
      .clock(clock), .reset(reset), .ctl(ctl_e), .radicand(bbx_e_ff),
      .side_in({bbz_e_ff, bxm_e_ff}), .out_valid(sq_valid), .root(nb), .side_out(sq_side)
   );

   stage_ctl_type ctl_sq;
   logic [KNW-1:0] knum;
   logic kd_valid;
   logic [MW-1:0] kq;
   logic kover, kbbz;

   assign ctl_sq = '{advance: adv, valid: sq_valid};
   assign knum = (KNW'(sq_side[BXMW-1:0]) << INDEX_PRESHIFT) + KNW'(nb >> 1);

   dvml_div #(.NW(KNW), .DW(NBW), .QW(MW), .SW(1)) u_div_index (
      .clock(clock), .reset(reset), .ctl(ctl_sq), .num(knum), .den(nb),
      .side_in(sq_side[BXMW]), .out_valid(kd_valid), .quot(kq), .over(kover),
      .side_out(kbbz)
   );

   logic [MW-1:0] kidx;
   always_comb begin
      priority if (kbbz) kidx = '0;
      else if (kover || (kq > MW'(M))) kidx = MW'(M);
      else kidx = kq;
   end

   logic v_r_ff;
   logic [WEIGHT_BITS-1:0] wt_r_ff;

   always_ff @(posedge clock) begin
      if (reset) v_r_ff <= 1'b0;
      else if (adv) v_r_ff <= kd_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) wt_r_ff <= SIG_ROM[kidx];
   end

   // align branches
   stage_ctl_type ctl_wa, ctl_sb;
   logic wa_valid, sb_valid;
   logic [WEIGHT_BITS-1:0] wt_al;
   logic [BW-1:0] sb_al;

   assign ctl_wa = '{advance: adv, valid: v_r_ff};
   assign ctl_sb = '{advance: adv, valid: ve_valid && vs_valid};

   dvml_delay #(.W(WEIGHT_BITS), .DEPTH(LAT_MAX - LAT_A)) u_align_weight (
      .clock(clock), .reset(reset), .ctl(ctl_wa), .data_in(wt_r_ff),
      .out_valid(wa_valid), .data_out(wt_al)
   );

   dvml_delay #(.W(BW), .DEPTH(LAT_MAX - LAT_B)) u_align_speed (
      .clock(clock), .reset(reset), .ctl(ctl_sb), .data_in({qe, ove, qs, ovs, zd_se, zd_ss}),
      .out_valid(sb_valid), .data_out(sb_al)
   );

   logic [SPEED_CAP_BITS-1:0] ve_sel, vs_sel;
   logic cap_e, cap_s, zd_al;

   always_comb begin
      cap_e = sb_al[SPEED_CAP_BITS+3];
      cap_s = sb_al[2];
      ve_sel = cap_e ? SPEED_CAP : sb_al[BW-1 -: SPEED_CAP_BITS];
      vs_sel = cap_s ? SPEED_CAP : sb_al[SPEED_CAP_BITS+2:3];
      zd_al = sb_al[1] | sb_al[0];
   end

   // stage M: weighted products
   localparam int MPW = SPEED_CAP_BITS + WEIGHT_BITS;
   logic v_m_ff;
   logic [MPW-1:0] pe_m_ff, ps_m_ff;
   logic capflag_m_ff, zd_m_ff;

   always_ff @(posedge clock) begin
      if (reset) v_m_ff <= 1'b0;
      else if (adv) v_m_ff <= wa_valid && sb_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pe_m_ff <= MPW'(ve_sel) * MPW'(WEIGHT_ONE - wt_al);
         ps_m_ff <= MPW'(vs_sel) * MPW'(wt_al);
         capflag_m_ff <= (cap_s && (wt_al != '0)) || (cap_e && (wt_al != WEIGHT_ONE));
         zd_m_ff <= zd_al;
      end
   end

   // output stage: round, saturate, force zero on zero drag
   logic [MPW:0] mix_sum;
   logic [MPW-16:0] mix;
   logic sat_in;

   always_comb begin
      mix_sum = (MPW+1)'(pe_m_ff) + (MPW+1)'(ps_m_ff) + (MPW+1)'(32768);
      mix = (MPW-15)'(mix_sum >> 16);
      sat_in = capflag_m_ff || (mix > (MPW-15)'({VELOCITY_BITS{1'b1}}));
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= v_m_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_zd_ff <= zd_m_ff;
         rsp_sat_ff <= !zd_m_ff && sat_in;
         priority if (zd_m_ff) rsp_vel_ff <= '0;
         else if (sat_in) rsp_vel_ff <= '1;
         else rsp_vel_ff <= VELOCITY_BITS'(mix);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_glide_velocity = rsp_vel_ff;
   assign rsp_zero_drag = rsp_zd_ff;
   assign rsp_saturated = rsp_sat_ff;
endmodule

FILE: design/dvml_checker.sv
// Port-level checks for the glide-speed block, bound to the top level.
// Depends on dislocation_velocity_mobility_law_top_defines.svh.
`timescale 1ns / 1ps
`include "dislocation_velocity_mobility_law_top_defines.svh"
module dvml_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_glide_velocity,
   input logic        rsp_zero_drag,
   input logic        rsp_saturated
);
   `DVML_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
   `DVML_ASSERT(a_req_ready, req_ready == (!rsp_valid || rsp_ready))
   `DVML_ASSERT(a_zero_drag, rsp_valid && rsp_zero_drag |-> rsp_glide_velocity == 32'd0 && !rsp_saturated)
   `DVML_ASSERT(a_saturate, rsp_valid && rsp_saturated |-> rsp_glide_velocity == 32'hFFFF_FFFF)
   `DVML_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid)
endmodule

bind dislocation_velocity_mobility_law_top dvml_checker u_dvml_checker (.*);
